>>> design/iac_pkg.sv
// ----------------------------------------------------------------------------
// iac_pkg: shared types and constants of the attitude filter
// Widths, fixed-point constants, register codes and the arctangent table
// used by the vectoring unit and the top-level sequencer.
// ----------------------------------------------------------------------------
package iac_pkg;

   // default number of vectoring iterations
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int TAB_LEN = 24;
   localparam int TAB_IDX_W = 5;

   // datapath widths
   localparam int CORD_W = 34;   // vectoring x/y
   localparam int ANG_W = 26;    // angle accumulator, Q10.16 degrees
   localparam int MUL_A_W = 34;
   localparam int MUL_B_W = 23;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // angle constants in Q10.16 degrees
   localparam logic signed [ANG_W-1:0] HALF_TURN = 26'sd11796480;
   localparam logic signed [ANG_W-1:0] FULL_TURN = 26'sd23592960;

   // rate gains
   localparam logic signed [MUL_B_W-1:0] INT_GAIN = 23'sd479753;
   localparam logic signed [MUL_B_W-1:0] YAW_GAIN = 23'sd3748068;
   localparam logic [16:0] WEIGHT_ONE = 17'd65536;

   // register indexes
   localparam logic [1:0] CSR_GYRO_Z_BIAS = 2'd0;
   localparam logic [1:0] CSR_GAP_THRESHOLD = 2'd1;
   localparam logic [1:0] CSR_WEIGHT_NEAR = 2'd2;
   localparam logic [1:0] CSR_WEIGHT_FAR = 2'd3;

   // register reset values
   localparam logic [15:0] BIAS_RST = 16'd0;
   localparam logic [8:0] THR_RST = 9'd10;
   localparam logic [16:0] WNEAR_RST = 17'd62259;
   localparam logic [16:0] WFAR_RST = 17'd52429;

   // request and response of the vectoring unit
   typedef struct packed {
      logic start;
      logic [16:0] y;
      logic [15:0] x;
   } cordic_req_type;

   typedef struct packed {
      logic done;
      logic [ANG_W-1:0] angle;
   } cordic_rsp_type;

   // atan(2^-i) in unsigned Q6.16 degrees
   function automatic logic [21:0] atan_entry(input logic [TAB_IDX_W-1:0] idx);
      logic [21:0] val;
      unique case (idx)
         5'd0: val = 22'd2949120;
         5'd1: val = 22'd1740967;
         5'd2: val = 22'd919879;
         5'd3: val = 22'd466945;
         5'd4: val = 22'd234379;
         5'd5: val = 22'd117304;
         5'd6: val = 22'd58666;
         5'd7: val = 22'd29335;
         5'd8: val = 22'd14668;
         5'd9: val = 22'd7334;
         5'd10: val = 22'd3667;
         5'd11: val = 22'd1833;
         5'd12: val = 22'd917;
         5'd13: val = 22'd458;
         5'd14: val = 22'd229;
         5'd15: val = 22'd115;
         5'd16: val = 22'd57;
         5'd17: val = 22'd29;
         5'd18: val = 22'd14;
         5'd19: val = 22'd7;
         5'd20: val = 22'd4;
         5'd21: val = 22'd2;
         5'd22: val = 22'd1;
         default: val = 22'd0;
      endcase
      return val;
   endfunction

endpackage

>>> design/iac_cordic.sv
// ----------------------------------------------------------------------------
// iac_cordic: iterative atan2 in degrees
// Vectoring-mode rotation unit, one micro-rotation per cycle, with the
// left-half-plane pre-rotation, the zero-vector case and the final clamp.
// ----------------------------------------------------------------------------
module iac_cordic #(
   parameter int STEPS = iac_pkg::CORDIC_STEPS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  iac_pkg::cordic_req_type req,
   output iac_pkg::cordic_rsp_type rsp
);
   import iac_pkg::*;

   localparam int CW = (STEPS > 1) ? $clog2(STEPS) : 1;
   localparam logic [CW-1:0] LAST = CW'(STEPS - 1);

   typedef enum logic [1:0] {S_IDLE, S_RUN, S_FIN} state_type;

   state_type state_ff;
   logic [CW-1:0] cnt_ff;
   logic signed [CORD_W-1:0] x_ff, y_ff;
   logic signed [ANG_W-1:0] z_ff;
   logic zero_ff;
   logic done_ff;
   logic signed [ANG_W-1:0] angle_ff;

   logic signed [CORD_W-1:0] xs, ys, x_start, y_start;
   logic signed [ANG_W-1:0] z_start;
   logic signed [CORD_W-1:0] dx, dy, x_in, y_in;
   logic signed [ANG_W-1:0] step_ang, z_in, clamp_in;

   // operand scaling and left-half-plane pre-rotation
   always_comb begin
      xs = {{18{req.x[15]}}, req.x} << 14;
      ys = {{17{req.y[16]}}, req.y} << 14;
      if (req.x[15]) begin
         x_start = -xs;
         y_start = -ys;
         z_start = req.y[16] ? -HALF_TURN : HALF_TURN;
      end else begin
         x_start = xs;
         y_start = ys;
         z_start = '0;
      end
   end

   // one micro-rotation toward y = 0
   always_comb begin
      dx = x_ff >>> cnt_ff;
      dy = y_ff >>> cnt_ff;
      step_ang = signed'(ANG_W'(atan_entry(TAB_IDX_W'(cnt_ff))));
      if (!y_ff[CORD_W-1] && (y_ff != '0)) begin
         x_in = x_ff + dy;
         y_in = y_ff - dx;
         z_in = z_ff + step_ang;
      end else begin
         x_in = x_ff - dy;
         y_in = y_ff + dx;
         z_in = z_ff - step_ang;
      end
   end

   // clamp to the half turn, zero vector gives zero
   always_comb begin
      if (zero_ff) begin
         clamp_in = '0;
      end else if (z_ff > HALF_TURN) begin
         clamp_in = HALF_TURN;
      end else if (z_ff < -HALF_TURN) begin
         clamp_in = -HALF_TURN;
      end else begin
         clamp_in = z_ff;
      end
   end

   // sequencer and registered result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req.start) begin
                  x_ff <= x_start;
                  y_ff <= y_start;
                  z_ff <= z_start;
                  zero_ff <= (req.x == '0) && (req.y == '0);
                  cnt_ff <= '0;
                  state_ff <= S_RUN;
               end
            end
            S_RUN: begin
               x_ff <= x_in;
               y_ff <= y_in;
               z_ff <= z_in;
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == LAST) begin
                  state_ff <= S_FIN;
               end
            end
            S_FIN: begin
               angle_ff <= clamp_in;
               done_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp.done = done_ff;
   assign rsp.angle = angle_ff;

endmodule

>>> design/iac_mul.sv
// ----------------------------------------------------------------------------
// iac_mul: shared registered multiplier
// Signed product of the two operands, registered: available in the cycle after issue.
// ----------------------------------------------------------------------------
module iac_mul (
   input  logic                                  clock,
   input  logic signed [iac_pkg::MUL_A_W-1:0]    a,
   input  logic signed [iac_pkg::MUL_B_W-1:0]    b,
   output logic signed [iac_pkg::MUL_P_W-1:0]    p_ff
);
   import iac_pkg::*;

   logic signed [MUL_P_W-1:0] p_in;

   // product
   always_comb begin
      p_in = MUL_P_W'(a) * MUL_P_W'(b);
   end

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end

endmodule

>>> design/imu_complementary_attitude.sv
// ----------------------------------------------------------------------------
// imu_complementary_attitude: roll, pitch and yaw from one six-axis sample
// Complementary filter: accelerometer atan2 angles blended with gyro
// integrals, yaw integrated from the bias-corrected z rate.
// ----------------------------------------------------------------------------
// usage
// - req_ channel carries one raw sample (three accel, three gyro words) per
//   item; req_ready is high only while the block is idle
// - rsp_ channel returns roll and pitch in Q16.16 degrees, yaw in Q9.16, one
//   item per sample, held in an output register until rsp_ready takes it
// - csr_ port writes bias, gap threshold and the two weights; the user must
//   write them only when idle, as the block itself does not enforce it
// - a sample takes two passes through the one-rotation-per-cycle atan2 unit
//   and the shared multiplier steps; no new item is taken until the previous
//   result has moved into the output register
// - if the receiver stalls, the next item is accepted and processed but its
//   result waits in the sequencer until the output register is free
// - reset clears the integrals and yaw, loads register defaults and empties
//   the output register
// ----------------------------------------------------------------------------
module imu_complementary_attitude #(
   parameter int CORDIC_STEPS = iac_pkg::CORDIC_STEPS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_accel_x,
   input  logic signed [15:0] req_accel_y,
   input  logic signed [15:0] req_accel_z,
   input  logic signed [15:0] req_gyro_x,
   input  logic signed [15:0] req_gyro_y,
   input  logic signed [15:0] req_gyro_z,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_roll_deg,
   output logic signed [31:0] rsp_pitch_deg,
   output logic signed [24:0] rsp_yaw_deg,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [16:0]        csr_wdata
);
   import iac_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_ATAN, S_INC, S_INT, S_GAP, S_MUL, S_BLD,
      S_YINC, S_YADD, S_YWRAP, S_OUT
   } state_type;

   state_type state_ff;

   // configuration
   logic signed [15:0] bias_ff;
   logic [8:0] thr_ff;
   logic [16:0] wnear_ff, wfar_ff;

   // sample and filter state
   logic signed [15:0] ax_ff, az_ff, gx_ff, gy_ff, gz_ff;
   logic signed [31:0] roll_int_ff, pitch_int_ff;
   logic signed [24:0] yaw_ff;

   // working registers
   logic sel_ff;
   logic signed [ANG_W-1:0] acc_ff;
   logic signed [31:0] gi_ff;
   logic signed [CORD_W-1:0] diff_ff;
   logic [16:0] w_ff;
   logic signed [31:0] roll_ff, pitch_ff;
   logic signed [25:0] ysum_ff;

   // output register
   logic rsp_valid_ff;
   logic signed [31:0] rsp_roll_ff, rsp_pitch_ff;
   logic signed [24:0] rsp_yaw_ff;

   cordic_req_type cord_req;
   cordic_rsp_type cord_rsp;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [MUL_P_W-1:0] mul_p;

   logic req_fire;
   logic out_load;
   logic signed [31:0] integ_cur;
   logic signed [MUL_P_W-1:0] inc_full, bl_full, yinc_full;
   logic signed [33:0] sum_in;
   logic signed [31:0] gi_in;
   logic signed [CORD_W-1:0] diff_in, thr_wide;
   logic far_in;
   logic [16:0] wsel, w_in;
   logic signed [31:0] blend_in;
   logic signed [16:0] d_in;
   logic signed [25:0] ysum_in, ywrap;
   logic signed [24:0] yaw_in;

   assign req_fire = req_valid && (state_ff == S_IDLE);
   assign req_ready = (state_ff == S_IDLE);

   // finished item moves into the output register when it is free
   assign out_load = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ready);

   // atan2 unit: roll at accept, pitch once roll is done
   always_comb begin
      cord_req.start = req_fire || ((state_ff == S_ATAN) && cord_rsp.done && !sel_ff);
      if (state_ff == S_IDLE) begin
         cord_req.y = {req_accel_y[15], req_accel_y};
         cord_req.x = req_accel_z;
      end else begin
         cord_req.y = 17'd0 - {ax_ff[15], ax_ff};
         cord_req.x = az_ff;
      end
   end

   iac_cordic #(
      .STEPS(CORDIC_STEPS)
   ) u_cordic (
      .clock(clock),
      .reset(reset),
      .req  (req_fire ? cord_req : cord_req),
      .rsp  (cord_rsp)
   );

   // multiplier operand selection
   always_comb begin
      d_in = {gz_ff[15], gz_ff} - {bias_ff[15], bias_ff};
      unique case (state_ff)
         S_INC: begin
            mul_a = sel_ff ? {{18{gx_ff[15]}}, gx_ff} : {{18{gy_ff[15]}}, gy_ff};
            mul_b = INT_GAIN;
         end
         S_MUL: begin
            mul_a = diff_ff;
            mul_b = signed'({6'b0, w_ff});
         end
         S_YINC: begin
            mul_a = {{17{d_in[16]}}, d_in};
            mul_b = YAW_GAIN;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   iac_mul u_mul (
      .clock(clock),
      .a    (mul_a),
      .b    (mul_b),
      .p_ff (mul_p)
   );

   // integral update with saturation
   always_comb begin
      integ_cur = sel_ff ? pitch_int_ff : roll_int_ff;
      inc_full = (mul_p + 57'sd8388608) >>> 24;
      sum_in = {{2{integ_cur[31]}}, integ_cur} + inc_full[33:0];
      if ((sum_in[33:31] != 3'b000) && (sum_in[33:31] != 3'b111)) begin
         gi_in = sum_in[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         gi_in = sum_in[31:0];
      end
   end

   // disagreement test and weight choice
   always_comb begin
      diff_in = {{8{acc_ff[ANG_W-1]}}, acc_ff} - {{2{gi_ff[31]}}, gi_ff};
      thr_wide = signed'({9'b0, thr_ff, 16'b0});
      far_in = (diff_in > thr_wide) || (diff_in < -thr_wide);
      wsel = far_in ? wfar_ff : wnear_ff;
      w_in = (wsel > WEIGHT_ONE) ? WEIGHT_ONE : wsel;
   end

   // blend: integral plus weighted correction, rounded
   always_comb begin
      bl_full = (mul_p + 57'sd32768) >>> 16;
      blend_in = gi_ff + bl_full[31:0];
   end

   // yaw increment and wrap into the half-open turn
   always_comb begin
      yinc_full = (mul_p + 57'sd32768) >>> 16;
      ysum_in = {yaw_ff[24], yaw_ff} + yinc_full[25:0];
      if (ysum_ff > HALF_TURN) begin
         ywrap = ysum_ff - FULL_TURN;
      end else if (ysum_ff <= -HALF_TURN) begin
         ywrap = ysum_ff + FULL_TURN;
      end else begin
         ywrap = ysum_ff;
      end
      yaw_in = ywrap[24:0];
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bias_ff <= BIAS_RST;
         thr_ff <= THR_RST;
         wnear_ff <= WNEAR_RST;
         wfar_ff <= WFAR_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_GYRO_Z_BIAS: bias_ff <= csr_wdata[15:0];
            CSR_GAP_THRESHOLD: thr_ff <= csr_wdata[8:0];
            CSR_WEIGHT_NEAR: wnear_ff <= csr_wdata;
            CSR_WEIGHT_FAR: wfar_ff <= csr_wdata;
         endcase
      end
   end

   // sequencer, filter state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         sel_ff <= 1'b0;
         roll_int_ff <= '0;
         pitch_int_ff <= '0;
         yaw_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // output valid: set on a load, cleared when the receiver takes it
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  ax_ff <= req_accel_x;
                  az_ff <= req_accel_z;
                  gx_ff <= req_gyro_x;
                  gy_ff <= req_gyro_y;
                  gz_ff <= req_gyro_z;
                  sel_ff <= 1'b0;
                  state_ff <= S_ATAN;
               end
            end
            S_ATAN: begin
               if (cord_rsp.done) begin
                  acc_ff <= cord_rsp.angle;
                  state_ff <= S_INC;
               end
            end
            S_INC: state_ff <= S_INT;
            S_INT: begin
               gi_ff <= gi_in;
               state_ff <= S_GAP;
            end
            S_GAP: begin
               if (sel_ff) begin
                  pitch_int_ff <= gi_ff;
               end else begin
                  roll_int_ff <= gi_ff;
               end
               diff_ff <= diff_in;
               w_ff <= w_in;
               state_ff <= S_MUL;
            end
            S_MUL: state_ff <= S_BLD;
            S_BLD: begin
               if (sel_ff) begin
                  pitch_ff <= blend_in;
                  state_ff <= S_YINC;
               end else begin
                  roll_ff <= blend_in;
                  sel_ff <= 1'b1;
                  state_ff <= S_ATAN;
               end
            end
            S_YINC: state_ff <= S_YADD;
            S_YADD: begin
               ysum_ff <= ysum_in;
               state_ff <= S_YWRAP;
            end
            S_YWRAP: begin
               yaw_ff <= yaw_in;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (out_load) begin
                  rsp_roll_ff <= roll_ff;
                  rsp_pitch_ff <= pitch_ff;
                  rsp_yaw_ff <= yaw_ff;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_roll_deg = rsp_roll_ff;
   assign rsp_pitch_deg = rsp_pitch_ff;
   assign rsp_yaw_deg = rsp_yaw_ff;

endmodule
